// ===== design/integer_matrix_multiply_defines.svh =====
// assertion macros shared by the matrix multiply
`ifndef INTEGER_MATRIX_MULTIPLY_DEFINES_SVH
`define INTEGER_MATRIX_MULTIPLY_DEFINES_SVH

// same-cycle implication
`define IMM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("imm assertion failed");

// next-cycle implication
`define IMM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("imm assertion failed");

`endif

// ===== design/imm_pkg.sv =====
package imm_pkg;

  localparam int DEFAULT_MAX_DIM = 8;
  localparam int IDX_W = 3;
  localparam int ELEM_W = 16;
  localparam int PROD_W = 32;
  localparam int SUM_W = 35;
  localparam int CFG_W = 4;

  localparam logic [1:0] MODE_LOAD_A = 2'd0;
  localparam logic [1:0] MODE_LOAD_B = 2'd1;
  localparam logic [1:0] MODE_START  = 2'd2;

  localparam logic [1:0] REG_ROWS_A = 2'd0;
  localparam logic [1:0] REG_COLS_A = 2'd1;
  localparam logic [1:0] REG_ROWS_B = 2'd2;
  localparam logic [1:0] REG_COLS_B = 2'd3;

  // operand travelling along the cell chain
  typedef struct packed {
    logic                     valid;
    logic [IDX_W-1:0]         k;
    logic                     last;
    logic signed [ELEM_W-1:0] a;
  } tok_t;

  function automatic logic [CFG_W-1:0] used_dim(input logic [CFG_W-1:0] r,
                                                input logic [CFG_W-1:0] max_dim);
    logic [CFG_W-1:0] u;
    if (r == '0) begin
      u = CFG_W'(1);
    end else if (r > max_dim) begin
      u = max_dim;
    end else begin
      u = r;
    end
    return u;
  endfunction

endpackage

// ===== design/integer_matrix_multiply.sv =====
// start to first result: the a elements pass the a store read register, then the cell chain
// each row of c: cols_a feed steps, a wait in S_WAIT while they pass the cell chain,
// then cols_b results, each sent when the output is free; the a store read port sets the feed rate of one per cycle
// items are accepted only while idle; one start is worked on at a time
// reset clears control state and sets all dimension registers to 8; stores stay undefined
`include "integer_matrix_multiply_defines.svh"

module integer_matrix_multiply import imm_pkg::*; #(
  parameter int MAX_DIM = DEFAULT_MAX_DIM
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // elem_row, elem_col, elem_value
  input  logic [1:0]  s_tuser,  // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,  // out_row, out_col, product_value
  output logic        m_tlast,
  output logic [0:0]  m_tuser,  // dims_error
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int KW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int AW = $clog2(MAX_DIM * MAX_DIM);
  localparam int WW = $clog2(MAX_DIM + 2);

  typedef enum logic [2:0] {S_IDLE, S_FEED, S_WAIT, S_OUT, S_ERR} state_t;

  state_t state;
  logic [CFG_W-1:0] rows_a, cols_a, rows_b, cols_b;
  logic [CFG_W-1:0] ra, ca, rb, cb;
  logic [IDX_W-1:0] i, j, k;
  logic [WW-1:0]    w;

  logic [1:0]               mode;
  logic [IDX_W-1:0]         elem_row, elem_col;
  logic signed [ELEM_W-1:0] elem_value;
  logic accept, in_range, a_we;

  logic signed [ELEM_W-1:0] a_mem [MAX_DIM*MAX_DIM];
  logic signed [ELEM_W-1:0] a_rd;
  logic [AW-1:0] wr_addr, rd_addr;
  logic feed_v, feed_last;
  logic [IDX_W-1:0] feed_k;
  logic out_free, out_load;

  tok_t tok [MAX_DIM+1];
  logic signed [SUM_W-1:0] cell_res [MAX_DIM];

  assign mode       = s_tuser;
  assign elem_row   = s_tdata[2:0];
  assign elem_col   = s_tdata[5:3];
  assign elem_value = s_tdata[21:6];

  assign ra = used_dim(rows_a, CFG_W'(MAX_DIM));
  assign ca = used_dim(cols_a, CFG_W'(MAX_DIM));
  assign rb = used_dim(rows_b, CFG_W'(MAX_DIM));
  assign cb = used_dim(cols_b, CFG_W'(MAX_DIM));

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign in_range = ({1'b0, elem_row} < (IDX_W+1)'(MAX_DIM))
                 && ({1'b0, elem_col} < (IDX_W+1)'(MAX_DIM));
  assign a_we     = accept && (mode == MODE_LOAD_A) && in_range;
  assign wr_addr  = AW'(elem_row) * AW'(MAX_DIM) + AW'(elem_col);
  assign rd_addr  = AW'(i) * AW'(MAX_DIM) + AW'(k);
  assign out_free = !m_tvalid || m_tready;
  assign out_load = out_free && ((state == S_OUT) || (state == S_ERR));

  always_ff @(posedge clk) begin
    if (a_we) begin
      a_mem[wr_addr] <= elem_value;
    end
    a_rd <= a_mem[rd_addr];
  end

  assign tok[0].valid = feed_v;
  assign tok[0].k     = feed_k;
  assign tok[0].last  = feed_last;
  assign tok[0].a     = a_rd;

  for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
    imm_cell #(.MAX_DIM(MAX_DIM)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .tok_in (tok[c]),
      .tok_out(tok[c+1]),
      .b_we   (accept && (mode == MODE_LOAD_B) && in_range
               && (elem_col == IDX_W'(c))),
      .b_addr (elem_row),
      .b_data (elem_value),
      .res    (cell_res[c])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      feed_v   <= 1'b0;
      rows_a   <= CFG_W'(8);
      cols_a   <= CFG_W'(8);
      rows_b   <= CFG_W'(8);
      cols_b   <= CFG_W'(8);
      i        <= '0;
      j        <= '0;
      k        <= '0;
      w        <= '0;
    end else begin
      feed_v <= (state == S_FEED);
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ROWS_A: rows_a <= cfg_data;
          REG_COLS_A: cols_a <= cfg_data;
          REG_ROWS_B: rows_b <= cfg_data;
          REG_COLS_B: cols_b <= cfg_data;
          default:    rows_a <= rows_a;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (accept && (mode == MODE_START)) begin
            if (ca != rb) begin
              state <= S_ERR;
            end else begin
              i     <= '0;
              k     <= '0;
              state <= S_FEED;
            end
          end
        end
        S_ERR: begin
          if (out_free) begin
            m_tdata  <= '0;
            m_tlast  <= 1'b1;
            m_tuser  <= 1'b1;
            state    <= S_IDLE;
          end
        end
        S_FEED: begin
          feed_k    <= k;
          feed_last <= (CFG_W'(k) == ca - CFG_W'(1));
          if (CFG_W'(k) == ca - CFG_W'(1)) begin
            w     <= '0;
            state <= S_WAIT;
          end else begin
            k <= k + IDX_W'(1);
          end
        end
        S_WAIT: begin
          if (w == WW'(MAX_DIM + 1)) begin
            j     <= '0;
            state <= S_OUT;
          end else begin
            w <= w + WW'(1);
          end
        end
        S_OUT: begin
          if (out_free) begin
            m_tdata  <= {7'd0, cell_res[j[KW-1:0]], j, i};
            m_tlast  <= (CFG_W'(i) == ra - CFG_W'(1)) && (CFG_W'(j) == cb - CFG_W'(1));
            m_tuser  <= 1'b0;
            if (CFG_W'(j) == cb - CFG_W'(1)) begin
              if (CFG_W'(i) == ra - CFG_W'(1)) begin
                state <= S_IDLE;
              end else begin
                i     <= i + IDX_W'(1);
                k     <= '0;
                state <= S_FEED;
              end
            end else begin
              j <= j + IDX_W'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `IMM_ASSERT_NOW(a_err_last, m_tvalid && m_tuser[0], m_tlast)
  `IMM_ASSERT_NOW(a_err_zero, m_tvalid && m_tuser[0], m_tdata == '0)
  `IMM_ASSERT_NEXT(a_start_busy, s_tvalid && s_tready && (s_tuser == MODE_START), !s_tready)

endmodule

// ===== design/imm_cell.sv =====
module imm_cell import imm_pkg::*; #(
  parameter int MAX_DIM = DEFAULT_MAX_DIM
) (
  input  logic                    clk,
  input  logic                    rst,
  input  tok_t                    tok_in,
  output tok_t                    tok_out,
  input  logic                    b_we,
  input  logic [IDX_W-1:0]        b_addr,
  input  logic signed [ELEM_W-1:0] b_data,
  output logic signed [SUM_W-1:0] res
);

  localparam int KW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  // one column of b
  logic signed [ELEM_W-1:0] b_col [MAX_DIM];
  logic signed [SUM_W-1:0]  acc;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  sum;

  assign prod = tok_in.a * b_col[tok_in.k[KW-1:0]];
  assign sum  = ((tok_in.k == '0) ? '0 : acc)
              + {{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod};

  always_ff @(posedge clk) begin
    if (b_we) begin
      b_col[b_addr[KW-1:0]] <= b_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.k    <= tok_in.k;
    tok_out.last <= tok_in.last;
    tok_out.a    <= tok_in.a;
    if (tok_in.valid) begin
      acc <= sum;
      if (tok_in.last) begin
        res <= sum;
      end
    end
  end

endmodule

// ===== tb/tb_integer_matrix_multiply.sv =====
`timescale 1ns / 100ps

module tb_integer_matrix_multiply;
  import imm_pkg::*;

  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam int DIM = 8;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [34:0] value;
    logic               last;
    logic               err;
  } product_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  sel;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [15:0] value;
    bit          typed;
    product_t    exp_res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic m_tlast;
  logic [0:0] m_tuser;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  integer_matrix_multiply uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("tb_integer_matrix_multiply NOT OK");
    $finish;
  end

  logic signed [15:0] mat_a [DIM][DIM];
  logic signed [15:0] mat_b [DIM][DIM];
  bit written_a [DIM][DIM];
  bit written_b [DIM][DIM];
  logic [3:0] dim_reg [4];
  product_t products_q [$];
  int errors = 0;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;

  function automatic int eff_dim(input logic [3:0] r);
    if (r == 0) return 1;
    if (r > DIM) return DIM;
    return r;
  endfunction

  // expected products of one accepted item
  function automatic void predict_products(input logic [1:0] mode, input logic [2:0] r,
                                           input logic [2:0] c, input logic [15:0] v);
    int ra, ca, rb, cb;
    longint acc;
    product_t p;
    if (mode == MODE_LOAD_A) begin
      mat_a[r][c] = v;
      written_a[r][c] = 1'b1;
    end else if (mode == MODE_LOAD_B) begin
      mat_b[r][c] = v;
      written_b[r][c] = 1'b1;
    end else if (mode == MODE_START) begin
      ra = eff_dim(dim_reg[REG_ROWS_A]);
      ca = eff_dim(dim_reg[REG_COLS_A]);
      rb = eff_dim(dim_reg[REG_ROWS_B]);
      cb = eff_dim(dim_reg[REG_COLS_B]);
      if (ca != rb) begin
        p = '{3'd0, 3'd0, 35'sd0, 1'b1, 1'b1};
        products_q.push_back(p);
      end else begin
        for (int i = 0; i < ra; i++)
          for (int j = 0; j < cb; j++) begin
            acc = 0;
            for (int k = 0; k < ca; k++)
              acc += longint'(mat_a[i][k]) * longint'(mat_b[k][j]);
            p.row = 3'(i);
            p.col = 3'(j);
            p.value = acc[34:0];
            p.last = (i == ra - 1) && (j == cb - 1);
            p.err = 1'b0;
            products_q.push_back(p);
          end
      end
    end
  endfunction

  task automatic send_item(input logic [1:0] mode, input logic [2:0] r, input logic [2:0] c,
                           input logic [15:0] v, input bit typed, input product_t tex);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= {2'b00, v, c, r};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (typed) products_q.push_back(tex);
    else predict_products(mode, r, c, v);
  endtask

  // load any entry a start would read that has not been written yet
  task automatic load_missing();
    int ra, ca, cb;
    product_t none;
    none = '{3'd0, 3'd0, 35'sd0, 1'b0, 1'b0};
    ra = eff_dim(dim_reg[REG_ROWS_A]);
    ca = eff_dim(dim_reg[REG_COLS_A]);
    cb = eff_dim(dim_reg[REG_COLS_B]);
    if (ca != eff_dim(dim_reg[REG_ROWS_B])) return;
    for (int i = 0; i < ra; i++)
      for (int k = 0; k < ca; k++)
        if (!written_a[i][k])
          send_item(MODE_LOAD_A, 3'(i), 3'(k), 16'($urandom), 1'b0, none);
    for (int k = 0; k < ca; k++)
      for (int j = 0; j < cb; j++)
        if (!written_b[k][j])
          send_item(MODE_LOAD_B, 3'(k), 3'(j), 16'($urandom), 1'b0, none);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
    s_tvalid <= 1'b0;
    while (products_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    dim_reg[idx] = val;
  endtask

  // result side
  initial begin
    product_t e;
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      if (products_q.size() == 0) begin
        $error("unexpected product item row %0d col %0d", m_tdata[2:0], m_tdata[5:3]);
        errors++;
      end else begin
        e = products_q.pop_front();
        if (m_tdata[2:0] !== e.row) begin
          $error("out_row expected %0d got %0d", e.row, m_tdata[2:0]); errors++;
        end
        if (m_tdata[5:3] !== e.col) begin
          $error("out_col expected %0d got %0d", e.col, m_tdata[5:3]); errors++;
        end
        if (m_tdata[40:6] !== e.value) begin
          $error("product_value expected %0d got %0d", e.value, $signed(m_tdata[40:6]));
          errors++;
        end
        if (m_tlast !== e.last) begin
          $error("last expected %0d got %0d", e.last, m_tlast); errors++;
        end
        if (m_tuser[0] !== e.err) begin
          $error("dims_error expected %0d got %0d", e.err, m_tuser[0]); errors++;
        end
      end
    end
  end

  // stimulus
  initial begin
    stim_row_t tab [$];
    product_t none;
    int pick;
    logic [3:0] ca;
    none = '{3'd0, 3'd0, 35'sd0, 1'b0, 1'b0};
    for (int i = 0; i < 4; i++) dim_reg[i] = 4'd8;
    tab.push_back('{ROW_REG, REG_ROWS_A, 3'd0, 3'd0, 16'd1, 1'b0, none});
    tab.push_back('{ROW_REG, REG_COLS_A, 3'd0, 3'd0, 16'd1, 1'b0, none});
    tab.push_back('{ROW_REG, REG_ROWS_B, 3'd0, 3'd0, 16'd1, 1'b0, none});
    tab.push_back('{ROW_REG, REG_COLS_B, 3'd0, 3'd0, 16'd1, 1'b0, none});
    tab.push_back('{ROW_ITEM, MODE_LOAD_A, 3'd0, 3'd0, 16'h8000, 1'b0, none});
    tab.push_back('{ROW_ITEM, MODE_LOAD_B, 3'd0, 3'd0, 16'h8000, 1'b0, none});
    tab.push_back('{ROW_ITEM, MODE_START, 3'd7, 3'd7, 16'hffff, 1'b1,
                    '{3'd0, 3'd0, 35'sd1073741824, 1'b1, 1'b0}});
    tab.push_back('{ROW_ITEM, MODE_LOAD_A, 3'd0, 3'd0, 16'h7fff, 1'b0, none});
    tab.push_back('{ROW_ITEM, MODE_START, 3'd0, 3'd0, 16'h0000, 1'b1,
                    '{3'd0, 3'd0, -35'sd1073709056, 1'b1, 1'b0}});
    tab.push_back('{ROW_ITEM, MODE_NONE, 3'd7, 3'd7, 16'hffff, 1'b0, none});
    tab.push_back('{ROW_REG, REG_COLS_A, 3'd0, 3'd0, 16'd2, 1'b0, none});
    tab.push_back('{ROW_ITEM, MODE_START, 3'd0, 3'd0, 16'h0000, 1'b1,
                    '{3'd0, 3'd0, 35'sd0, 1'b1, 1'b1}});
    // zero counts as one on both sides, so no dimension error
    tab.push_back('{ROW_REG, REG_COLS_A, 3'd0, 3'd0, 16'd0, 1'b0, none});
    tab.push_back('{ROW_REG, REG_ROWS_B, 3'd0, 3'd0, 16'd0, 1'b0, none});
    tab.push_back('{ROW_ITEM, MODE_START, 3'd0, 3'd0, 16'h0000, 1'b1,
                    '{3'd0, 3'd0, -35'sd1073709056, 1'b1, 1'b0}});
    tab.push_back('{ROW_ITEM, MODE_LOAD_A, 3'd7, 3'd7, 16'h7fff, 1'b0, none});
    tab.push_back('{ROW_ITEM, MODE_LOAD_B, 3'd7, 3'd7, 16'h8000, 1'b0, none});
    tab.push_back('{ROW_REG, REG_ROWS_A, 3'd0, 3'd0, 16'd15, 1'b0, none});
    tab.push_back('{ROW_REG, REG_COLS_A, 3'd0, 3'd0, 16'd8, 1'b0, none});
    tab.push_back('{ROW_REG, REG_ROWS_B, 3'd0, 3'd0, 16'd9, 1'b0, none});
    tab.push_back('{ROW_REG, REG_COLS_B, 3'd0, 3'd0, 16'd15, 1'b0, none});
    tab.push_back('{ROW_ITEM, MODE_START, 3'd0, 3'd0, 16'h0000, 1'b0, none});

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (tab[n]) begin
      if (tab[n].kind == ROW_REG) begin
        write_reg(tab[n].sel, tab[n].value[3:0]);
      end else begin
        if (tab[n].sel == MODE_START) load_missing();
        send_item(tab[n].sel, tab[n].row, tab[n].col, tab[n].value,
                  tab[n].typed, tab[n].exp_res);
      end
    end

    for (int ph = 0; ph < 6; ph++) begin
      no_idle = (ph % 3 == 2);
      if (ph == 0) begin
        for (int i = 0; i < 4; i++) write_reg(2'(i), 4'd8);
      end else if (ph == 1) begin
        for (int i = 0; i < 4; i++) write_reg(2'(i), 4'd1);
      end else begin
        ca = 4'($urandom_range(0, 15));
        write_reg(REG_ROWS_A, 4'($urandom_range(0, 15)));
        write_reg(REG_COLS_A, ca);
        write_reg(REG_ROWS_B, ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : ca);
        write_reg(REG_COLS_B, 4'($urandom_range(0, 15)));
      end
      if (ph == 0) begin
        // long result stall; further loads wait until the start is done
        hold_req = 1'b1;
        load_missing();
        send_item(MODE_START, 3'd0, 3'd0, 16'h0000, 1'b0, none);
      end
      for (int n = 0; n < 6; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          load_missing();
          send_item(MODE_START, 3'($urandom), 3'($urandom), 16'($urandom), 1'b0, none);
        end else if (pick < 14) begin
          send_item(MODE_NONE, 3'($urandom), 3'($urandom), 16'($urandom), 1'b0, none);
        end else if (pick < 30) begin
          send_item(2'($urandom_range(0, 1)), 3'($urandom), 3'($urandom),
                    16'($urandom), 1'b0, none);
        end else begin
          send_item(2'($urandom_range(0, 1)),
                    3'($urandom_range(0, eff_dim(dim_reg[REG_ROWS_A]) - 1)),
                    3'($urandom_range(0, eff_dim(dim_reg[REG_COLS_B]) - 1)),
                    16'($urandom), 1'b0, none);
        end
      end
      load_missing();
      send_item(MODE_START, 3'd0, 3'd0, 16'h0000, 1'b0, none);
    end

    s_tvalid <= 1'b0;
    while (products_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_integer_matrix_multiply OK");
    end else begin
      $display("tb_integer_matrix_multiply NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/imm_pkg.sv
design/imm_cell.sv
design/integer_matrix_multiply.sv
tb/tb_integer_matrix_multiply.sv
